// ===== rtl/bde_pkg.sv =====
package bde_pkg;

    // Default button count and the smallest set that counts as a combo
    localparam int DEF_NUM_BUTTONS = 6;
    localparam int COMBO_MIN       = 2;

    // Field and register widths
    localparam int TS_W   = 32;
    localparam int DEB_W  = 12;
    localparam int SCAN_W = 8;
    localparam int LONG_W = 16;
    localparam int ST_W   = 13;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 12'd30;
    localparam logic [SCAN_W-1:0] SCAN_RST       = 8'd5;
    localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd800;
    localparam logic              ACTIVE_LOW_RST = 1'b1;

    typedef enum logic [2:0] {
        EV_PRESSED        = 3'd0,
        EV_RELEASED       = 3'd1,
        EV_SHORT          = 3'd2,
        EV_LONG           = 3'd3,
        EV_COMBO_PRESSED  = 3'd4,
        EV_COMBO_RELEASED = 3'd5
    } evt_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_SCAN       = 2'd1,
        REG_LONG_PRESS = 2'd2,
        REG_ACTIVE_LOW = 2'd3
    } reg_idx_t;

endpackage

// ===== rtl/button_debounce_event_engine.sv =====
// Channel   Direction  Payload                                           Handshake
// s_        in         raw_levels, now_ms (one scan tick)                s_valid / s_ready
// m_        out        event_type, button_index, event_mask,             m_valid / m_ready
//                      duration_ms, timestamp_ms, last
// apb       in/out     debounce, scan period, long press, polarity       psel/penable/pready
//
// On a tick, state is updated and every event it causes goes into a slot
// buffer (two slots per button, two for combos) that drains one event per cycle,
// while m_ready allows, into the output register; it holds 2*NUM_BUTTONS+2 slots.
// The next tick is taken in the cycle in which the final event moves out.
// A stalled m_ready holds the output register and, through it, the buffer.
// Synchronous active-low reset clears state, buffer and output valid.
module button_debounce_event_engine #(
    parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // scan tick request
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [NUM_BUTTONS-1:0]                 s_raw_levels,
    input  logic [bde_pkg::TS_W-1:0]               s_now_ms,
    // event request
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output bde_pkg::evt_t                          m_event_type,
    output logic [$clog2(NUM_BUTTONS+1)-1:0]       m_button_index,
    output logic [NUM_BUTTONS-1:0]                 m_event_mask,
    output logic [bde_pkg::TS_W-1:0]               m_duration_ms,
    output logic [bde_pkg::TS_W-1:0]               m_timestamp_ms,
    output logic                                   m_last,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bde_pkg::APB_AW-1:0]             paddr,
    input  logic [bde_pkg::APB_DW-1:0]             pwdata,
    output logic [bde_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);
    import bde_pkg::*;

    localparam int NSLOT = 2 * NUM_BUTTONS + 2;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int BTN_W = $clog2(NUM_BUTTONS);
    localparam int IDX_W = $clog2(NUM_BUTTONS + 1);
    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DEB_W-1:0]  debounce_reg;
    logic [SCAN_W-1:0] scan_reg;
    logic [LONG_W-1:0] long_press_reg;
    logic              active_low_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            scan_reg       <= SCAN_RST;
            long_press_reg <= LONG_PRESS_RST;
            active_low_reg <= ACTIVE_LOW_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEBOUNCE:   debounce_reg   <= pwdata[DEB_W-1:0];
                REG_SCAN:       scan_reg       <= pwdata[SCAN_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[LONG_W-1:0];
                REG_ACTIVE_LOW: active_low_reg <= pwdata[0];
                default:        debounce_reg   <= debounce_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DEBOUNCE:   prdata = {{(APB_DW-DEB_W){1'b0}}, debounce_reg};
            REG_SCAN:       prdata = {{(APB_DW-SCAN_W){1'b0}}, scan_reg};
            REG_LONG_PRESS: prdata = {{(APB_DW-LONG_W){1'b0}}, long_press_reg};
            REG_ACTIVE_LOW: prdata = {{(APB_DW-1){1'b0}}, active_low_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Per-button state
    // ---------------------------------------------------------------
    logic [NUM_BUTTONS-1:0] last_raw_reg, last_raw_next;
    logic [NUM_BUTTONS-1:0] lvl_reg, lvl_next;
    logic [NUM_BUTTONS-1:0] long_sent_reg, long_sent_next;
    logic [NUM_BUTTONS-1:0] combo_used_reg, combo_used_next;
    logic [NUM_BUTTONS-1:0] combo_mask_reg, combo_mask_next;
    logic [ST_W-1:0]        stable_reg [NUM_BUTTONS];
    logic [ST_W-1:0]        stable_next [NUM_BUTTONS];
    logic [TS_W-1:0]        press_time_reg [NUM_BUTTONS];
    logic [TS_W-1:0]        press_time_next [NUM_BUTTONS];

    // per-button decisions for the tick on the input
    logic [NUM_BUTTONS-1:0] down_v, chg_v, press_v, rel_v, short_v, long_v, ls_v;
    logic [TS_W-1:0]        evdur_v [NUM_BUTTONS];

    // combo decisions
    logic [CNT_W-1:0]       down_cnt;
    logic                   combo_v, crel_v, cpress_v;
    logic [NUM_BUTTONS-1:0] cm_after;

    // new slot contents
    logic [NSLOT-1:0]       new_pend;
    evt_t                   new_type [NSLOT];

    always_comb begin
        last_raw_next   = last_raw_reg;
        lvl_next        = lvl_reg;
        long_sent_next  = long_sent_reg;
        combo_used_next = combo_used_reg;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            down_v[i] = s_raw_levels[i] ^ active_low_reg;
            if (down_v[i] == last_raw_reg[i]) begin
                // grow the stable time until it reaches the debounce time
                if (stable_reg[i] < {1'b0, debounce_reg}) begin
                    stable_next[i] = stable_reg[i] + {{(ST_W-SCAN_W){1'b0}}, scan_reg};
                end else begin
                    stable_next[i] = stable_reg[i];
                end
            end else begin
                last_raw_next[i] = down_v[i];
                stable_next[i]   = '0;
            end
            chg_v[i]   = (stable_next[i] >= {1'b0, debounce_reg}) && (down_v[i] != lvl_reg[i]);
            press_v[i] = chg_v[i] && down_v[i];
            rel_v[i]   = chg_v[i] && !down_v[i];
            if (chg_v[i]) begin
                lvl_next[i] = down_v[i];
            end
            press_time_next[i] = press_v[i] ? s_now_ms : press_time_reg[i];
            evdur_v[i] = press_v[i] ? '0 : (s_now_ms - press_time_reg[i]);
            short_v[i] = rel_v[i] && !long_sent_reg[i] && !combo_used_reg[i];
            ls_v[i]    = press_v[i] ? 1'b0 : long_sent_reg[i];
            if (press_v[i]) begin
                long_sent_next[i]  = 1'b0;
                combo_used_next[i] = 1'b0;
            end
            long_v[i] = lvl_next[i] && !ls_v[i]
                        && (evdur_v[i] >= {{(TS_W-LONG_W){1'b0}}, long_press_reg});
            if (long_v[i]) begin
                long_sent_next[i]  = 1'b1;
                combo_used_next[i] = 1'b1;
            end
        end

        down_cnt = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            down_cnt = down_cnt + CNT_W'(lvl_next[i]);
        end
        combo_v  = down_cnt >= CNT_W'(COMBO_MIN);
        crel_v   = (combo_mask_reg != '0) && (!combo_v || (lvl_next != combo_mask_reg));
        cm_after = crel_v ? '0 : combo_mask_reg;
        cpress_v = combo_v && (lvl_next != cm_after);
        combo_mask_next = cpress_v ? lvl_next : cm_after;
        if (cpress_v) begin
            combo_used_next = combo_used_next | lvl_next;
        end

        for (int i = 0; i < NUM_BUTTONS; i++) begin
            new_pend[2*i]     = chg_v[i] || long_v[i];
            new_pend[2*i + 1] = press_v[i] ? long_v[i] : short_v[i];
            new_type[2*i]     = press_v[i] ? EV_PRESSED : (rel_v[i] ? EV_RELEASED : EV_LONG);
            new_type[2*i + 1] = press_v[i] ? EV_LONG : EV_SHORT;
        end
        new_pend[NSLOT-2] = crel_v;
        new_pend[NSLOT-1] = cpress_v;
        new_type[NSLOT-2] = EV_COMBO_RELEASED;
        new_type[NSLOT-1] = EV_COMBO_PRESSED;
    end

    // ---------------------------------------------------------------
    // Event slot buffer and drain
    // ---------------------------------------------------------------
    logic [NSLOT-1:0]       pend_reg, pend_next;
    evt_t                   slot_type_reg [NSLOT];
    logic [TS_W-1:0]        btn_dur_reg [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] crel_mask_reg, cpress_mask_reg;
    logic [TS_W-1:0]        ts_reg;

    logic [SLOT_W-1:0]      sel_idx;
    logic [BTN_W-1:0]       sel_btn;
    logic [NSLOT-1:0]       remaining;
    logic                   load_out;
    logic                   s_accept;
    logic                   sel_combo;

    // lowest pending slot goes first: that is button order, then combos
    always_comb begin
        sel_idx = '0;
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (pend_reg[k]) begin
                sel_idx = SLOT_W'(k);
            end
        end
    end

    assign sel_btn   = sel_idx[BTN_W:1];
    assign sel_combo = sel_idx >= SLOT_W'(2 * NUM_BUTTONS);
    assign remaining = pend_reg & ~(NSLOT'(1) << sel_idx);
    assign load_out  = (pend_reg != '0) && (!m_valid || m_ready);
    assign s_ready   = (pend_reg == '0) || (load_out && (remaining == '0));
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            pend_next = new_pend;
        end else if (load_out) begin
            pend_next = remaining;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg   <= '0;
            lvl_reg        <= '0;
            long_sent_reg  <= '0;
            combo_used_reg <= '0;
            combo_mask_reg <= '0;
            pend_reg       <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                stable_reg[i] <= {1'b0, DEBOUNCE_RST};
            end
        end else begin
            pend_reg <= pend_next;
            if (s_accept) begin
                last_raw_reg   <= last_raw_next;
                lvl_reg        <= lvl_next;
                long_sent_reg  <= long_sent_next;
                combo_used_reg <= combo_used_next;
                combo_mask_reg <= combo_mask_next;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    stable_reg[i] <= stable_next[i];
                end
            end
        end
    end

    // payload of the state and the buffer: written on a tick, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_time_reg[i] <= press_time_next[i];
                btn_dur_reg[i]    <= evdur_v[i];
            end
            for (int k = 0; k < NSLOT; k++) begin
                slot_type_reg[k] <= new_type[k];
            end
            crel_mask_reg   <= combo_mask_reg;
            cpress_mask_reg <= lvl_next;
            ts_reg          <= s_now_ms;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic          m_valid_reg;
    evt_t          m_type_reg;
    logic [IDX_W-1:0]       m_idx_reg;
    logic [NUM_BUTTONS-1:0] m_mask_reg;
    logic [TS_W-1:0]        m_dur_reg, m_ts_reg;
    logic                   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_type_reg <= slot_type_reg[sel_idx];
            m_ts_reg   <= ts_reg;
            m_last_reg <= (remaining == '0);
            if (sel_combo) begin
                m_idx_reg  <= IDX_W'(NUM_BUTTONS);
                m_mask_reg <= sel_idx[0] ? cpress_mask_reg : crel_mask_reg;
                m_dur_reg  <= '0;
            end else begin
                m_idx_reg  <= IDX_W'(sel_btn);
                m_mask_reg <= NUM_BUTTONS'(1) << sel_btn;
                m_dur_reg  <= btn_dur_reg[sel_btn];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_type   = m_type_reg;
    assign m_button_index = m_idx_reg;
    assign m_event_mask   = m_mask_reg;
    assign m_duration_ms  = m_dur_reg;
    assign m_timestamp_ms = m_ts_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    // a new tick is taken only when at most the final event is left
    a_ready_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> ($countones(pend_reg) <= 1))
        else $error("tick taken while events still pending");

    // an active combo is always the current debounced set
    a_combo_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (combo_mask_reg != '0) |-> (combo_mask_reg == lvl_reg))
        else $error("combo mask out of step with debounced levels");

    // every button in an active combo is marked as consumed
    a_combo_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (combo_mask_reg & ~combo_used_reg) == '0)
        else $error("combo button without consumed mark");

    // an event marked last leaves nothing behind in the buffer
    a_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_last == (pend_reg == '0)) || s_accept || $past(s_accept))
        else $error("last flag does not match buffer state");
`endif

endmodule
